// ----- rtl/sip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_pkg
// Shared constants and types for the segment intersection point block.
// ----------------------------------------------------------------------------
package sip_pkg;

   // default coordinate width
   localparam int COORD_BITS_DEF = 16;

   // per-item control flags that travel with the pipeline
   typedef struct packed {
      logic hit;      // a crossing point is reported
      logic use_div;  // point comes from the line-line quotient
      logic neg_x;    // x quotient is negative
      logic neg_y;    // y quotient is negative
   } ctl_type;

endpackage

// ----- rtl/sip_geom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_geom
// Six-stage front end: differences, products, orientations and determinant,
// hit decision with split numerator products, numerator sums, magnitudes.
// ----------------------------------------------------------------------------
module sip_geom #(
   parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic signed [COORD_BITS-1:0]      in_x1,
   input  logic signed [COORD_BITS-1:0]      in_y1,
   input  logic signed [COORD_BITS-1:0]      in_x2,
   input  logic signed [COORD_BITS-1:0]      in_y2,
   input  logic signed [COORD_BITS-1:0]      in_x3,
   input  logic signed [COORD_BITS-1:0]      in_y3,
   input  logic signed [COORD_BITS-1:0]      in_x4,
   input  logic signed [COORD_BITS-1:0]      in_y4,
   output logic                              out_valid,
   output sip_pkg::ctl_type                  out_ctl,
   output logic [3*COORD_BITS+2:0]           out_mag_x,
   output logic [3*COORD_BITS+2:0]           out_mag_y,
   output logic [2*COORD_BITS+2:0]           out_mag_d,
   output logic signed [COORD_BITS-1:0]      out_px,
   output logic signed [COORD_BITS-1:0]      out_py
);

   localparam int C  = COORD_BITS;
   localparam int DW = C + 1;
   localparam int PW = 2 * C + 2;
   localparam int OW = 2 * C + 3;
   localparam int CW = 2 * C + 1;
   localparam int NW = 3 * C + 3;

   function automatic logic signed [DW-1:0] diff(input logic signed [C-1:0] a,
                                                 input logic signed [C-1:0] b);
      diff = DW'(a) - DW'(b);
   endfunction

   // point (px,py) inside the box spanned by (ax,ay)-(bx,by)
   function automatic logic in_box(input logic signed [C-1:0] ax,
                                   input logic signed [C-1:0] ay,
                                   input logic signed [C-1:0] bx,
                                   input logic signed [C-1:0] by,
                                   input logic signed [C-1:0] px,
                                   input logic signed [C-1:0] py);
      in_box = ((px <= ax) || (px <= bx)) && ((px >= ax) || (px >= bx)) &&
               ((py <= ay) || (py <= by)) && ((py >= ay) || (py >= by));
   endfunction

   // ------------------------------------------------------------------
   // stage 1: coordinate differences
   // ------------------------------------------------------------------
   logic                 s1_valid_ff;
   logic signed [C-1:0]  s1_x1_ff, s1_y1_ff, s1_x2_ff, s1_y2_ff;
   logic signed [C-1:0]  s1_x3_ff, s1_y3_ff, s1_x4_ff, s1_y4_ff;
   logic signed [DW-1:0] s1_dy21_ff, s1_dx32_ff, s1_dx21_ff, s1_dy32_ff;
   logic signed [DW-1:0] s1_dx42_ff, s1_dy42_ff, s1_dy43_ff, s1_dx14_ff;
   logic signed [DW-1:0] s1_dx43_ff, s1_dy14_ff, s1_dx24_ff, s1_dy24_ff;
   logic signed [DW-1:0] s1_dx12_ff, s1_dy34_ff, s1_dy12_ff, s1_dx34_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
      if (advance) begin
         s1_x1_ff   <= in_x1;
         s1_y1_ff   <= in_y1;
         s1_x2_ff   <= in_x2;
         s1_y2_ff   <= in_y2;
         s1_x3_ff   <= in_x3;
         s1_y3_ff   <= in_y3;
         s1_x4_ff   <= in_x4;
         s1_y4_ff   <= in_y4;
         s1_dy21_ff <= diff(in_y2, in_y1);
         s1_dx32_ff <= diff(in_x3, in_x2);
         s1_dx21_ff <= diff(in_x2, in_x1);
         s1_dy32_ff <= diff(in_y3, in_y2);
         s1_dx42_ff <= diff(in_x4, in_x2);
         s1_dy42_ff <= diff(in_y4, in_y2);
         s1_dy43_ff <= diff(in_y4, in_y3);
         s1_dx14_ff <= diff(in_x1, in_x4);
         s1_dx43_ff <= diff(in_x4, in_x3);
         s1_dy14_ff <= diff(in_y1, in_y4);
         s1_dx24_ff <= diff(in_x2, in_x4);
         s1_dy24_ff <= diff(in_y2, in_y4);
         s1_dx12_ff <= diff(in_x1, in_x2);
         s1_dy34_ff <= diff(in_y3, in_y4);
         s1_dy12_ff <= diff(in_y1, in_y2);
         s1_dx34_ff <= diff(in_x3, in_x4);
      end
   end

   // ------------------------------------------------------------------
   // stage 2: orientation, determinant and cross products; box tests
   // ------------------------------------------------------------------
   logic                 s2_valid_ff;
   logic signed [PW-1:0] s2_prod_ff [0:13];
   logic signed [DW-1:0] s2_dx12_ff, s2_dy12_ff, s2_dx34_ff, s2_dy34_ff;
   logic signed [C-1:0]  s2_x3_ff, s2_y3_ff, s2_x4_ff, s2_y4_ff;
   logic                 s2_box_b0_ff, s2_box_b1_ff, s2_box_a0_ff, s2_box_a1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_prod_ff[0]  <= PW'(s1_dy21_ff * s1_dx32_ff);
         s2_prod_ff[1]  <= PW'(s1_dx21_ff * s1_dy32_ff);
         s2_prod_ff[2]  <= PW'(s1_dy21_ff * s1_dx42_ff);
         s2_prod_ff[3]  <= PW'(s1_dx21_ff * s1_dy42_ff);
         s2_prod_ff[4]  <= PW'(s1_dy43_ff * s1_dx14_ff);
         s2_prod_ff[5]  <= PW'(s1_dx43_ff * s1_dy14_ff);
         s2_prod_ff[6]  <= PW'(s1_dy43_ff * s1_dx24_ff);
         s2_prod_ff[7]  <= PW'(s1_dx43_ff * s1_dy24_ff);
         s2_prod_ff[8]  <= PW'(s1_dx12_ff * s1_dy34_ff);
         s2_prod_ff[9]  <= PW'(s1_dy12_ff * s1_dx34_ff);
         s2_prod_ff[10] <= PW'(s1_x1_ff * s1_y2_ff);
         s2_prod_ff[11] <= PW'(s1_y1_ff * s1_x2_ff);
         s2_prod_ff[12] <= PW'(s1_x3_ff * s1_y4_ff);
         s2_prod_ff[13] <= PW'(s1_y3_ff * s1_x4_ff);
         s2_dx12_ff     <= s1_dx12_ff;
         s2_dy12_ff     <= s1_dy12_ff;
         s2_dx34_ff     <= s1_dx34_ff;
         s2_dy34_ff     <= s1_dy34_ff;
         s2_x3_ff       <= s1_x3_ff;
         s2_y3_ff       <= s1_y3_ff;
         s2_x4_ff       <= s1_x4_ff;
         s2_y4_ff       <= s1_y4_ff;
         s2_box_b0_ff   <= in_box(s1_x1_ff, s1_y1_ff, s1_x2_ff, s1_y2_ff,
                                  s1_x3_ff, s1_y3_ff);
         s2_box_b1_ff   <= in_box(s1_x1_ff, s1_y1_ff, s1_x2_ff, s1_y2_ff,
                                  s1_x4_ff, s1_y4_ff);
         s2_box_a0_ff   <= in_box(s1_x3_ff, s1_y3_ff, s1_x4_ff, s1_y4_ff,
                                  s1_x1_ff, s1_y1_ff);
         s2_box_a1_ff   <= in_box(s1_x3_ff, s1_y3_ff, s1_x4_ff, s1_y4_ff,
                                  s1_x2_ff, s1_y2_ff);
      end
   end

   // ------------------------------------------------------------------
   // stage 3: orientation signs, determinant, line constants
   // ------------------------------------------------------------------
   logic                 s3_valid_ff;
   logic [3:0]           s3_zero_ff, s3_neg_ff;
   logic signed [OW-1:0] s3_den_ff;
   logic signed [CW-1:0] s3_ca_ff, s3_cb_ff;
   logic signed [DW-1:0] s3_dx12_ff, s3_dy12_ff, s3_dx34_ff, s3_dy34_ff;
   logic signed [C-1:0]  s3_x3_ff, s3_y3_ff, s3_x4_ff, s3_y4_ff;
   logic                 s3_box_b0_ff, s3_box_b1_ff, s3_box_a0_ff, s3_box_a1_ff;
   logic signed [OW-1:0] orient_val [0:3];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         orient_val[i] = OW'(s2_prod_ff[2*i]) - OW'(s2_prod_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            s3_zero_ff[i] <= (orient_val[i] == '0);
            s3_neg_ff[i]  <= orient_val[i][OW-1];
         end
         s3_den_ff    <= OW'(s2_prod_ff[8]) - OW'(s2_prod_ff[9]);
         s3_ca_ff     <= CW'(s2_prod_ff[10]) - CW'(s2_prod_ff[11]);
         s3_cb_ff     <= CW'(s2_prod_ff[12]) - CW'(s2_prod_ff[13]);
         s3_dx12_ff   <= s2_dx12_ff;
         s3_dy12_ff   <= s2_dy12_ff;
         s3_dx34_ff   <= s2_dx34_ff;
         s3_dy34_ff   <= s2_dy34_ff;
         s3_x3_ff     <= s2_x3_ff;
         s3_y3_ff     <= s2_y3_ff;
         s3_x4_ff     <= s2_x4_ff;
         s3_y4_ff     <= s2_y4_ff;
         s3_box_b0_ff <= s2_box_b0_ff;
         s3_box_b1_ff <= s2_box_b1_ff;
         s3_box_a0_ff <= s2_box_a0_ff;
         s3_box_a1_ff <= s2_box_a1_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: hit decision, collinear point, split numerator products
   // ------------------------------------------------------------------
   logic                 ne12, ne34, meet, den_zero;
   logic signed [DW-1:0] ca_hi, ca_lo, cb_hi, cb_lo;
   sip_pkg::ctl_type     ctl4;
   logic signed [C-1:0]  px4, py4;

   assign ne12 = (s3_zero_ff[0] != s3_zero_ff[1]) ||
                 (!s3_zero_ff[0] && (s3_neg_ff[0] != s3_neg_ff[1]));
   assign ne34 = (s3_zero_ff[2] != s3_zero_ff[3]) ||
                 (!s3_zero_ff[2] && (s3_neg_ff[2] != s3_neg_ff[3]));
   assign meet = (ne12 && ne34) ||
                 (s3_zero_ff[0] && s3_box_b0_ff) || (s3_zero_ff[1] && s3_box_b1_ff) ||
                 (s3_zero_ff[2] && s3_box_a0_ff) || (s3_zero_ff[3] && s3_box_a1_ff);
   assign den_zero = (s3_den_ff == '0);

   // constants split into a signed high half and an unsigned low half
   assign ca_hi = s3_ca_ff[CW-1:C];
   assign ca_lo = $signed({1'b0, s3_ca_ff[C-1:0]});
   assign cb_hi = s3_cb_ff[CW-1:C];
   assign cb_lo = $signed({1'b0, s3_cb_ff[C-1:0]});

   // collinear case picks B start, then B end
   always_comb begin
      ctl4    = '0;
      px4     = s3_x3_ff;
      py4     = s3_y3_ff;
      if (!den_zero) begin
         ctl4.hit     = meet;
         ctl4.use_div = meet;
      end else if (s3_zero_ff[0] && s3_box_b0_ff) begin
         ctl4.hit = 1'b1;
      end else if (s3_zero_ff[0] && s3_box_b1_ff) begin
         ctl4.hit = 1'b1;
         px4      = s3_x4_ff;
         py4      = s3_y4_ff;
      end
   end

   logic                 s4_valid_ff;
   sip_pkg::ctl_type     s4_ctl_ff;
   logic signed [PW-1:0] s4_part_ff [0:7];
   logic signed [OW-1:0] s4_den_ff;
   logic signed [C-1:0]  s4_px_ff, s4_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_ctl_ff     <= ctl4;
         s4_part_ff[0] <= PW'(ca_hi * s3_dx34_ff);
         s4_part_ff[1] <= PW'(ca_lo * s3_dx34_ff);
         s4_part_ff[2] <= PW'(cb_hi * s3_dx12_ff);
         s4_part_ff[3] <= PW'(cb_lo * s3_dx12_ff);
         s4_part_ff[4] <= PW'(ca_hi * s3_dy34_ff);
         s4_part_ff[5] <= PW'(ca_lo * s3_dy34_ff);
         s4_part_ff[6] <= PW'(cb_hi * s3_dy12_ff);
         s4_part_ff[7] <= PW'(cb_lo * s3_dy12_ff);
         s4_den_ff     <= s3_den_ff;
         s4_px_ff      <= px4;
         s4_py_ff      <= py4;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: numerator sums
   // ------------------------------------------------------------------
   logic                 s5_valid_ff;
   sip_pkg::ctl_type     s5_ctl_ff;
   logic signed [NW-1:0] s5_nx_ff, s5_ny_ff;
   logic signed [OW-1:0] s5_den_ff;
   logic signed [C-1:0]  s5_px_ff, s5_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
      if (advance) begin
         s5_ctl_ff <= s4_ctl_ff;
         s5_nx_ff  <= ((NW'(s4_part_ff[0]) - NW'(s4_part_ff[2])) <<< C) +
                      (NW'(s4_part_ff[1]) - NW'(s4_part_ff[3]));
         s5_ny_ff  <= ((NW'(s4_part_ff[4]) - NW'(s4_part_ff[6])) <<< C) +
                      (NW'(s4_part_ff[5]) - NW'(s4_part_ff[7]));
         s5_den_ff <= s4_den_ff;
         s5_px_ff  <= s4_px_ff;
         s5_py_ff  <= s4_py_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 6: magnitudes and quotient signs
   // ------------------------------------------------------------------
   logic                 s6_valid_ff;
   sip_pkg::ctl_type     s6_ctl_ff;
   logic [NW-1:0]        s6_mag_x_ff, s6_mag_y_ff;
   logic [OW-1:0]        s6_mag_d_ff;
   logic signed [C-1:0]  s6_px_ff, s6_py_ff;
   sip_pkg::ctl_type     ctl6;

   always_comb begin
      ctl6       = s5_ctl_ff;
      ctl6.neg_x = s5_nx_ff[NW-1] ^ s5_den_ff[OW-1];
      ctl6.neg_y = s5_ny_ff[NW-1] ^ s5_den_ff[OW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= s5_valid_ff;
      end
      if (advance) begin
         s6_ctl_ff   <= ctl6;
         s6_mag_x_ff <= s5_nx_ff[NW-1] ? NW'(-s5_nx_ff) : NW'(s5_nx_ff);
         s6_mag_y_ff <= s5_ny_ff[NW-1] ? NW'(-s5_ny_ff) : NW'(s5_ny_ff);
         s6_mag_d_ff <= s5_den_ff[OW-1] ? OW'(-s5_den_ff) : OW'(s5_den_ff);
         s6_px_ff    <= s5_px_ff;
         s6_py_ff    <= s5_py_ff;
      end
   end

   assign out_valid = s6_valid_ff;
   assign out_ctl   = s6_ctl_ff;
   assign out_mag_x = s6_mag_x_ff;
   assign out_mag_y = s6_mag_y_ff;
   assign out_mag_d = s6_mag_d_ff;
   assign out_px    = s6_px_ff;
   assign out_py    = s6_py_ff;

endmodule

// ----- rtl/sip_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_div
// Pipelined restoring divider for both axes, one quotient bit per stage,
// sharing one divisor. Side data travels with each stage.
// ----------------------------------------------------------------------------
module sip_div #(
   parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  sip_pkg::ctl_type              in_ctl,
   input  logic [3*COORD_BITS+2:0]       in_mag_x,
   input  logic [3*COORD_BITS+2:0]       in_mag_y,
   input  logic [2*COORD_BITS+2:0]       in_mag_d,
   input  logic signed [COORD_BITS-1:0]  in_px,
   input  logic signed [COORD_BITS-1:0]  in_py,
   output logic                          out_valid,
   output sip_pkg::ctl_type              out_ctl,
   output logic [COORD_BITS:0]           out_qx,
   output logic [COORD_BITS:0]           out_qy,
   output logic signed [COORD_BITS-1:0]  out_px,
   output logic signed [COORD_BITS-1:0]  out_py
);

   localparam int C  = COORD_BITS;
   localparam int Q  = C + 1;
   localparam int OW = 2 * C + 3;
   localparam int RW = 3 * C + 3;

   logic                valid_ff [0:Q-1];
   sip_pkg::ctl_type    ctl_ff   [0:Q-1];
   logic [RW-1:0]       rx_ff    [0:Q-1];
   logic [RW-1:0]       ry_ff    [0:Q-1];
   logic [Q-1:0]        qx_ff    [0:Q-1];
   logic [Q-1:0]        qy_ff    [0:Q-1];
   logic [OW-1:0]       d_ff     [0:Q-1];
   logic signed [C-1:0] px_ff    [0:Q-1];
   logic signed [C-1:0] py_ff    [0:Q-1];

   for (genvar k = 0; k < Q; k++) begin : g_step
      localparam int SH = Q - 1 - k;

      logic                valid_cur;
      sip_pkg::ctl_type    ctl_cur;
      logic [RW-1:0]       rx_cur, ry_cur, dsh;
      logic [Q-1:0]        qx_cur, qy_cur;
      logic [OW-1:0]       d_cur;
      logic signed [C-1:0] px_cur, py_cur;
      logic                ge_x, ge_y;

      // stage input: port for the first step, previous step otherwise
      if (k == 0) begin : g_first
         assign valid_cur = in_valid;
         assign ctl_cur   = in_ctl;
         assign rx_cur    = in_mag_x;
         assign ry_cur    = in_mag_y;
         assign qx_cur    = '0;
         assign qy_cur    = '0;
         assign d_cur     = in_mag_d;
         assign px_cur    = in_px;
         assign py_cur    = in_py;
      end else begin : g_next
         assign valid_cur = valid_ff[k-1];
         assign ctl_cur   = ctl_ff[k-1];
         assign rx_cur    = rx_ff[k-1];
         assign ry_cur    = ry_ff[k-1];
         assign qx_cur    = qx_ff[k-1];
         assign qy_cur    = qy_ff[k-1];
         assign d_cur     = d_ff[k-1];
         assign px_cur    = px_ff[k-1];
         assign py_cur    = py_ff[k-1];
      end

      // trial subtract of the shifted divisor
      assign dsh  = RW'(d_cur) << SH;
      assign ge_x = (rx_cur >= dsh);
      assign ge_y = (ry_cur >= dsh);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_cur;
         end
         if (advance) begin
            ctl_ff[k] <= ctl_cur;
            rx_ff[k]  <= ge_x ? rx_cur - dsh : rx_cur;
            ry_ff[k]  <= ge_y ? ry_cur - dsh : ry_cur;
            qx_ff[k]  <= qx_cur | (Q'(ge_x) << SH);
            qy_ff[k]  <= qy_cur | (Q'(ge_y) << SH);
            d_ff[k]   <= d_cur;
            px_ff[k]  <= px_cur;
            py_ff[k]  <= py_cur;
         end
      end
   end

   assign out_valid = valid_ff[Q-1];
   assign out_ctl   = ctl_ff[Q-1];
   assign out_qx    = qx_ff[Q-1];
   assign out_qy    = qy_ff[Q-1];
   assign out_px    = px_ff[Q-1];
   assign out_py    = py_ff[Q-1];

endmodule

// ----- rtl/segment_intersection_point_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection_point_top
// Segment pair intersection: orientation test, collinear endpoint cases and
// the line-line crossing point with truncated quotients.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_a_x0 .. req_b_y1
//   rsp      out        rsp_valid / rsp_ready  rsp_hit, rsp_cross_x, rsp_cross_y
//
// Takes one segment pair per cycle while the output is not held; a pair passes
// through 6 geometry stages, COORD_BITS + 1 divider steps and 1 output register.
// The divider emits one quotient bit per stage, which sets the depth.
// Synchronous reset empties the pipeline. When the output is held, the whole
// pipeline holds and req_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module segment_intersection_point_top #(
   parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_BITS-1:0]  req_a_x0,
   input  logic signed [COORD_BITS-1:0]  req_a_y0,
   input  logic signed [COORD_BITS-1:0]  req_a_x1,
   input  logic signed [COORD_BITS-1:0]  req_a_y1,
   input  logic signed [COORD_BITS-1:0]  req_b_x0,
   input  logic signed [COORD_BITS-1:0]  req_b_y0,
   input  logic signed [COORD_BITS-1:0]  req_b_x1,
   input  logic signed [COORD_BITS-1:0]  req_b_y1,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic signed [COORD_BITS-1:0]  rsp_cross_x,
   output logic signed [COORD_BITS-1:0]  rsp_cross_y
);

   localparam int C  = COORD_BITS;
   localparam int Q  = C + 1;
   localparam int OW = 2 * C + 3;
   localparam int NW = 3 * C + 3;

   logic                advance;
   logic                g_valid;
   sip_pkg::ctl_type    g_ctl;
   logic [NW-1:0]       g_mag_x, g_mag_y;
   logic [OW-1:0]       g_mag_d;
   logic signed [C-1:0] g_px, g_py;
   logic                d_valid;
   sip_pkg::ctl_type    d_ctl;
   logic [Q-1:0]        d_qx, d_qy, qx_signed, qy_signed;
   logic signed [C-1:0] d_px, d_py;

   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic signed [C-1:0] rsp_cross_x_ff, rsp_cross_y_ff;
   logic signed [C-1:0] cross_x_in, cross_y_in;

   // whole pipeline moves when the output register is free or drained
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   sip_geom #(
      .COORD_BITS(COORD_BITS)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_x1     (req_a_x0),
      .in_y1     (req_a_y0),
      .in_x2     (req_a_x1),
      .in_y2     (req_a_y1),
      .in_x3     (req_b_x0),
      .in_y3     (req_b_y0),
      .in_x4     (req_b_x1),
      .in_y4     (req_b_y1),
      .out_valid (g_valid),
      .out_ctl   (g_ctl),
      .out_mag_x (g_mag_x),
      .out_mag_y (g_mag_y),
      .out_mag_d (g_mag_d),
      .out_px    (g_px),
      .out_py    (g_py)
   );

   sip_div #(
      .COORD_BITS(COORD_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (g_valid),
      .in_ctl    (g_ctl),
      .in_mag_x  (g_mag_x),
      .in_mag_y  (g_mag_y),
      .in_mag_d  (g_mag_d),
      .in_px     (g_px),
      .in_py     (g_py),
      .out_valid (d_valid),
      .out_ctl   (d_ctl),
      .out_qx    (d_qx),
      .out_qy    (d_qy),
      .out_px    (d_px),
      .out_py    (d_py)
   );

   // sign fix and point selection
   assign qx_signed  = d_ctl.neg_x ? Q'(-d_qx) : d_qx;
   assign qy_signed  = d_ctl.neg_y ? Q'(-d_qy) : d_qy;
   assign cross_x_in = !d_ctl.hit ? '0 : (d_ctl.use_div ? $signed(qx_signed[C-1:0]) : d_px);
   assign cross_y_in = !d_ctl.hit ? '0 : (d_ctl.use_div ? $signed(qy_signed[C-1:0]) : d_py);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= d_valid;
      end
      if (advance) begin
         rsp_hit_ff     <= d_ctl.hit;
         rsp_cross_x_ff <= cross_x_in;
         rsp_cross_y_ff <= cross_y_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_cross_x = rsp_cross_x_ff;
   assign rsp_cross_y = rsp_cross_y_ff;

   // no hit means a zero point
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_cross_x == '0 && rsp_cross_y == '0))
      else $error("miss transfer carries a nonzero point");

   // a held output freezes the divider tail
   a_hold_tail : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(d_valid))
      else $error("divider tail moved during a stall");

   // reset empties the output
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a quotient point needs a hit
   a_div_hit : assert property (@(posedge clock) disable iff (reset)
      (d_valid && d_ctl.use_div) |-> d_ctl.hit)
      else $error("quotient selected without a hit");

endmodule
